/* hdl/scf_pkg.sv */
// ============================================================================
// scf_pkg: shared types and constants of the stored frame checker
// Header layout constants, status codes, the frame state view and the
// byte-wide reflected CRC-32 step.
// ============================================================================
`timescale 1ns / 1ps

package scf_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC     = 32'h434C_4231;  // "CLB1"
  localparam logic [7:0]  VERSION   = 8'd1;
  localparam logic [7:0]  CODEC_STORED = 8'd0;
  localparam logic [63:0] RAW_LIMIT = 64'd8 << 30;
  localparam logic [63:0] HDR_LAST  = 64'd31;

  // Final status codes; scf_status ranks ST_UNSUPPORTED above ST_STORED_LEN.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_MAGIC       = 3'd1;
  localparam logic [2:0] ST_FLAGS       = 3'd2;
  localparam logic [2:0] ST_LENGTHS     = 3'd3;
  localparam logic [2:0] ST_FRAME_CRC   = 3'd4;
  localparam logic [2:0] ST_STORED_LEN  = 3'd5;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd6;
  localparam logic [2:0] ST_PAYLOAD_CRC = 3'd7;

  // Frame state as it stands after the current byte has been taken in.
  typedef struct packed {
    logic        fwd;
    logic        magic_ok;
    logic        flags_ok;
    logic [7:0]  codec;
    logic [63:0] raw_length;
    logic [63:0] payload_size;
    logic [31:0] exp_pay_crc;
    logic [31:0] exp_frm_crc;
    logic [31:0] run_pay_crc;
    logic [31:0] run_frm_crc;
  } scf_view_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
    end
    return x;
  endfunction

  function automatic logic [7:0] magic_byte(logic [1:0] idx);
    return MAGIC[8 * (3 - 32'(idx)) +: 8];
  endfunction

endpackage

/* hdl/scf_in_if.sv */
// ============================================================================
// scf_in_if: frame byte channel
// Valid/ready channel that carries one frame byte and its end marker.
// ============================================================================
`timescale 1ns / 1ps

interface scf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

/* hdl/scf_out_if.sv */
// ============================================================================
// scf_out_if: result channel
// Valid/ready channel that carries a forwarded payload byte and/or a status.
// ============================================================================
`timescale 1ns / 1ps

interface scf_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] payload_byte;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output byte_valid, output payload_byte,
                  output done_res, output status, input ready);
  modport sink   (input valid, input byte_valid, input payload_byte,
                  input done_res, input status, output ready);
endinterface

/* hdl/stored_frame_checker.sv */
// ============================================================================
// stored_frame_checker: archive frame checker with stored payload pass-through
// Checks one frame byte by byte, forwards stored payload, reports a status.
// ============================================================================
`timescale 1ns / 1ps

// The checker accepts one frame byte per clock cycle and sustains that rate
// indefinitely as long as the result side keeps taking items. Each byte passes
// an input register, then header capture, a byte-wide CRC-32 step on the
// running CRCs and the status decision, and lands in the output register. A
// byte whose result finds the output register still occupied waits in the
// input register. Bytes that produce no result (header bytes other than the
// last one of a frame, and payload of a compressed frame) are absorbed without
// using the output register. Payload bytes of a stored frame are forwarded
// before the frame's status is known; a consumer must drop them when the final
// status is nonzero. The status comes with the frame's last byte, which is
// marked by frame_end. Input ready drops only while the output register holds
// an item that the sink has not taken and the next byte would produce another
// one. The accepted codec register may be written only while no frame byte is
// in flight, and it is sampled when the last byte of a frame is checked.

module stored_frame_checker
  import scf_pkg::*;
#(
  parameter int COUNT_BITS = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  scf_in_if.sink     in_ch,
  scf_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Configuration register.
  logic [7:0] codec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= CODEC_STORED;
    end else if (cfg_we) begin
      codec_r <= cfg_wdata;
    end
  end

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // Output register.
  logic       out_vld_r;
  logic       ob_valid_r;
  logic [7:0] ob_byte_r;
  logic       ob_done_r;
  logic [2:0] ob_status_r;

  logic                  produces, out_free, advance;
  logic [COUNT_BITS-1:0] offset;
  scf_view_t             view;
  logic [2:0]            fin_status;

  // An item in the input register moves on when it needs no output slot or
  // when the output register is empty or being emptied this cycle.
  assign produces     = view.fwd || in_end_r;
  assign out_free     = !out_vld_r || out_ch.ready;
  assign advance      = in_vld_r && (!produces || out_free);
  assign in_ch.ready  = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.frame_byte;
      in_end_r  <= in_ch.frame_end;
    end
  end

  scf_state #(
    .COUNT_BITS (COUNT_BITS)
  ) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .last   (in_end_r),
    .data   (in_byte_r),
    .offset (offset),
    .view   (view)
  );

  scf_status #(
    .COUNT_BITS (COUNT_BITS)
  ) u_status (
    .offset         (offset),
    .view           (view),
    .accepted_codec (codec_r),
    .status         (fin_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && produces) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Fields that carry no information are zero, so a result is fully defined.
  always_ff @(posedge clk) begin
    if (advance && produces) begin
      ob_valid_r  <= view.fwd;
      ob_byte_r   <= view.fwd ? in_byte_r : 8'd0;
      ob_done_r   <= in_end_r;
      ob_status_r <= in_end_r ? fin_status : ST_OK;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.byte_valid   = ob_valid_r;
  assign out_ch.payload_byte = ob_byte_r;
  assign out_ch.done_res     = ob_done_r;
  assign out_ch.status       = ob_status_r;

  // A result is always a forwarded byte, a frame status, or both.
  a_result_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (ob_valid_r || ob_done_r))
    else $error("result item carries neither a byte nor a status");

  // Status is only reported on the frame's last byte.
  a_status_only_done : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !ob_done_r) |-> (ob_status_r == ST_OK))
    else $error("status reported on a non-final item");

  // Once a frame's last byte has been processed, the next frame starts at offset zero.
  a_frame_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_end_r) |=> (offset == '0))
    else $error("byte counter not cleared after frame end");

  // A byte that needs an output slot never overwrites a result still waiting.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready && in_vld_r && produces) |-> !advance)
    else $error("pending result overwritten");

endmodule

/* hdl/scf_state.sv */
// ============================================================================
// scf_state: frame state registers
// Byte counter, header field capture and the two running CRC-32s.
// ============================================================================
`timescale 1ns / 1ps

module scf_state
  import scf_pkg::*;
#(
  parameter int COUNT_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  last,
  input  logic [7:0]            data,
  output logic [COUNT_BITS-1:0] offset,
  output scf_view_t             view
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  scf_view_t             st_r, st_nxt, upd;

  assign offset = count_r;
  assign view   = upd;

  always_comb begin
    upd     = st_r;
    upd.fwd = 1'b0;
    if (count_r < COUNT_BITS'(4)) begin
      if (data != magic_byte(count_r[1:0])) upd.magic_ok = 1'b0;
    end else if (count_r == COUNT_BITS'(4)) begin
      if (data != VERSION) upd.flags_ok = 1'b0;
    end else if (count_r == COUNT_BITS'(5)) begin
      upd.codec = data;
    end else if (count_r < COUNT_BITS'(8)) begin
      if (data != 8'd0) upd.flags_ok = 1'b0;
    end else if (count_r < COUNT_BITS'(16)) begin
      upd.raw_length = {st_r.raw_length[55:0], data};
    end else if (count_r < COUNT_BITS'(24)) begin
      upd.payload_size = {st_r.payload_size[55:0], data};
    end else if (count_r < COUNT_BITS'(28)) begin
      upd.exp_pay_crc = {st_r.exp_pay_crc[23:0], data};
    end else if (count_r < COUNT_BITS'(32)) begin
      upd.exp_frm_crc = {st_r.exp_frm_crc[23:0], data};
    end

    // The frame CRC skips the stored frame CRC word; the payload CRC starts
    // at the first payload byte.
    if (count_r < COUNT_BITS'(28)) begin
      upd.run_frm_crc = crc32_byte(st_r.run_frm_crc, data);
    end else if (count_r >= COUNT_BITS'(32)) begin
      upd.run_frm_crc = crc32_byte(st_r.run_frm_crc, data);
      upd.run_pay_crc = crc32_byte(st_r.run_pay_crc, data);
      upd.fwd         = (st_r.codec == CODEC_STORED);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    if (step) begin
      if (last) begin
        st_nxt    = '{fwd: 1'b0, magic_ok: 1'b1, flags_ok: 1'b1, codec: '0,
                      raw_length: '0, payload_size: '0, exp_pay_crc: '0,
                      exp_frm_crc: '0, run_pay_crc: CRC_INIT, run_frm_crc: CRC_INIT};
        count_nxt = '0;
      end else begin
        st_nxt    = upd;
        count_nxt = (count_r == CountMax) ? count_r : count_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      st_r    <= '{fwd: 1'b0, magic_ok: 1'b1, flags_ok: 1'b1, codec: '0,
                   raw_length: '0, payload_size: '0, exp_pay_crc: '0,
                   exp_frm_crc: '0, run_pay_crc: CRC_INIT, run_frm_crc: CRC_INIT};
    end else begin
      count_r <= count_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

/* hdl/scf_status.sv */
// ============================================================================
// scf_status: final frame status
// Picks the first failing check from the updated frame state.
// ============================================================================
`timescale 1ns / 1ps

module scf_status
  import scf_pkg::*;
#(
  parameter int COUNT_BITS = 40
) (
  input  logic [COUNT_BITS-1:0] offset,
  input  scf_view_t             view,
  input  logic [7:0]            accepted_codec,
  output logic [2:0]            status
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic short_frame, codec_bad, len_bad;

  assign short_frame = offset < COUNT_BITS'(31);
  assign codec_bad   = (view.codec != CODEC_STORED) && (view.codec != accepted_codec);
  // Short frames are caught first, so the subtraction never wraps when used.
  assign len_bad     = (view.raw_length > RAW_LIMIT) || (offset == CountMax) ||
                       (view.payload_size != 64'(offset) - HDR_LAST);

  always_comb begin
    if (short_frame || !view.magic_ok) begin
      status = ST_MAGIC;
    end else if (!view.flags_ok || codec_bad) begin
      status = ST_FLAGS;
    end else if (len_bad) begin
      status = ST_LENGTHS;
    end else if (~view.run_frm_crc != view.exp_frm_crc) begin
      status = ST_FRAME_CRC;
    end else if (view.codec != CODEC_STORED) begin
      status = ST_UNSUPPORTED;
    end else if (view.raw_length != view.payload_size) begin
      status = ST_STORED_LEN;
    end else if (~view.run_pay_crc != view.exp_pay_crc) begin
      status = ST_PAYLOAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

endmodule
